FILE: src/tot_pkg.sv
package tot_pkg;

    localparam int MAX_HOUR_DIGITS_DEF = 6;
    localparam int FRACTION_DIGITS_DEF = 3;
    localparam int QUEUE_DEPTH_DEF     = 2;

    localparam int HOURS_W  = 20;
    localparam int FRAC_W   = 10;
    localparam int FCNT_W   = 2;
    localparam int SECS_W   = 32;
    localparam int MS_W     = 10;
    localparam int NS_W     = 62;
    localparam int OFFSET_W = 63;

    localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SEC_PER_MIN  = 6'd60;
    localparam logic [29:0] NS_PER_S     = 30'd1000000000;
    localparam logic [19:0] NS_PER_MS    = 20'd1000000;

    typedef enum logic [1:0] {
        ST_VALID   = 2'd0,
        ST_AUTO    = 2'd1,
        ST_SYNTAX  = 2'd2,
        ST_NEGZERO = 2'd3
    } t_status;

    // One parsed string, as handed from the parser to the arithmetic side.
    typedef struct packed {
        t_status             kind;
        logic                neg;
        logic [HOURS_W-1:0]  hours;
        logic [5:0]          minutes;
        logic [5:0]          seconds;
        logic [FRAC_W-1:0]   frac;
        logic [FCNT_W-1:0]   frac_digits;
    } t_job;

    typedef struct packed {
        logic push;
        t_job job;
    } t_q_wr;

    typedef struct packed {
        logic full;
        logic empty;
        t_job job;
    } t_q_rd;

    // Scale that right-pads a fraction of the given digit count to milliseconds.
    function automatic logic [6:0] frac_scale(input logic [FCNT_W-1:0] digits);
        logic [6:0] s;
        case (digits)
            2'd1:    s = 7'd100;
            2'd2:    s = 7'd10;
            default: s = 7'd1;
        endcase
        return s;
    endfunction

endpackage

FILE: src/tot_in_if.sv
interface tot_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       last_char;

    modport source (output valid, output text_char, output last_char, input ready);
    modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

FILE: src/tot_out_if.sv
interface tot_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [62:0] nano_offset;

    modport source (output valid, output status, output nano_offset, input ready);
    modport sink   (input valid, input status, input nano_offset, output ready);
endinterface

FILE: src/tot_front.sv
module tot_front
    import tot_pkg::*;
#(
    parameter int MAX_HOUR_DIGITS = MAX_HOUR_DIGITS_DEF,
    parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_text_char,
    input  logic       i_last_char,
    input  logic       i_full,
    output t_q_wr      o_wr
);

    localparam int CNT_W = $clog2(MAX_HOUR_DIGITS + 1);

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_FIVE  = 8'h35;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    typedef enum logic [3:0] {
        P_START, P_SIGN, P_HOURS, P_MIN0, P_MIN1, P_COLON2, P_SEC0,
        P_SEC1, P_SECEND, P_FRAC, P_AU1, P_AU2, P_AU3, P_AUTO
    } t_phase;

    t_phase             r_phase, n_phase;
    logic               r_neg, n_neg;
    logic [HOURS_W-1:0] r_hours, n_hours;
    logic [5:0]         r_min, n_min;
    logic [5:0]         r_sec, n_sec;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [FRAC_W-1:0]  r_frac, n_frac;
    logic               r_failed, n_failed;

    logic       is_dig, is_dig05, ok, accept;
    logic [3:0] d;

    assign o_ready  = !i_full;
    assign accept   = i_valid && o_ready;
    assign is_dig   = (i_text_char >= CH_ZERO) && (i_text_char <= CH_NINE);
    assign is_dig05 = (i_text_char >= CH_ZERO) && (i_text_char <= CH_FIVE);
    assign d        = is_dig ? i_text_char[3:0] : 4'd0;

    always_comb begin
        n_phase  = r_phase;
        n_neg    = r_neg;
        n_hours  = r_hours;
        n_min    = r_min;
        n_sec    = r_sec;
        n_count  = r_count;
        n_frac   = r_frac;
        ok       = 1'b0;
        unique case (r_phase)
            P_START: begin
                if (i_text_char == CH_MINUS) begin
                    n_neg = 1'b1; n_phase = P_SIGN; ok = 1'b1;
                end else if (i_text_char == CH_A) begin
                    n_phase = P_AU1; ok = 1'b1;
                end else if (is_dig) begin
                    n_hours = HOURS_W'(d); n_count = CNT_W'(1); n_phase = P_HOURS; ok = 1'b1;
                end
            end
            P_SIGN: begin
                if (is_dig) begin
                    n_hours = HOURS_W'(d); n_count = CNT_W'(1); n_phase = P_HOURS; ok = 1'b1;
                end
            end
            P_HOURS: begin
                if (is_dig && (r_count < CNT_W'(MAX_HOUR_DIGITS))) begin
                    n_hours = HOURS_W'((HOURS_W + 4)'(r_hours) * (HOURS_W + 4)'(10)
                              + (HOURS_W + 4)'(d));
                    n_count = r_count + CNT_W'(1);
                    ok      = 1'b1;
                end else if ((i_text_char == CH_COLON) && (r_count >= CNT_W'(2))) begin
                    n_phase = P_MIN0; ok = 1'b1;
                end
            end
            P_MIN0: begin
                if (is_dig05) begin
                    n_min = 6'(d) * 6'd10; n_phase = P_MIN1; ok = 1'b1;
                end
            end
            P_MIN1: begin
                if (is_dig) begin
                    n_min = r_min + 6'(d); n_phase = P_COLON2; ok = 1'b1;
                end
            end
            P_COLON2: begin
                if (i_text_char == CH_COLON) begin
                    n_phase = P_SEC0; ok = 1'b1;
                end
            end
            P_SEC0: begin
                if (is_dig05) begin
                    n_sec = 6'(d) * 6'd10; n_phase = P_SEC1; ok = 1'b1;
                end
            end
            P_SEC1: begin
                if (is_dig) begin
                    n_sec = r_sec + 6'(d); n_phase = P_SECEND; ok = 1'b1;
                end
            end
            P_SECEND: begin
                if (i_text_char == CH_DOT) begin
                    n_count = '0; n_frac = '0; n_phase = P_FRAC; ok = 1'b1;
                end
            end
            P_FRAC: begin
                if (is_dig && (r_count < CNT_W'(FRACTION_DIGITS))) begin
                    n_frac  = FRAC_W'((FRAC_W + 4)'(r_frac) * (FRAC_W + 4)'(10)
                              + (FRAC_W + 4)'(d));
                    n_count = r_count + CNT_W'(1);
                    ok      = 1'b1;
                end
            end
            P_AU1: begin
                if (i_text_char == CH_U) begin
                    n_phase = P_AU2; ok = 1'b1;
                end
            end
            P_AU2: begin
                if (i_text_char == CH_T) begin
                    n_phase = P_AU3; ok = 1'b1;
                end
            end
            P_AU3: begin
                if (i_text_char == CH_O) begin
                    n_phase = P_AUTO; ok = 1'b1;
                end
            end
            default: ok = 1'b0;
        endcase
        // Once the pattern is broken, the rest of the string is ignored.
        if (r_failed) begin
            n_phase = r_phase;
            n_neg   = r_neg;
            n_hours = r_hours;
            n_min   = r_min;
            n_sec   = r_sec;
            n_count = r_count;
            n_frac  = r_frac;
        end
        n_failed = r_failed || !ok;
    end

    always_comb begin
        o_wr.push            = accept && i_last_char;
        o_wr.job.neg         = n_neg;
        o_wr.job.hours       = n_hours;
        o_wr.job.minutes     = n_min;
        o_wr.job.seconds     = n_sec;
        o_wr.job.frac        = (n_phase == P_FRAC) ? n_frac : '0;
        o_wr.job.frac_digits = FCNT_W'(n_count);
        if (n_failed) begin
            o_wr.job.kind = ST_SYNTAX;
        end else if (n_phase == P_AUTO) begin
            o_wr.job.kind = ST_AUTO;
        end else if ((n_phase == P_SECEND) || ((n_phase == P_FRAC) && (n_count != '0))) begin
            o_wr.job.kind = ST_VALID;
        end else begin
            o_wr.job.kind = ST_SYNTAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_last_char)) begin
            r_phase  <= P_START;
            r_neg    <= 1'b0;
            r_hours  <= '0;
            r_min    <= '0;
            r_sec    <= '0;
            r_count  <= '0;
            r_frac   <= '0;
            r_failed <= 1'b0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_neg    <= n_neg;
            r_hours  <= n_hours;
            r_min    <= n_min;
            r_sec    <= n_sec;
            r_count  <= n_count;
            r_frac   <= n_frac;
            r_failed <= n_failed;
        end
    end

endmodule

FILE: src/tot_queue.sv
module tot_queue
    import tot_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_q_wr i_wr,
    input  logic  i_pop,
    output t_q_rd o_rd
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_rd.full  = (r_count == CNT_W'(DEPTH));
    assign o_rd.empty = (r_count == '0);
    assign o_rd.job   = r_mem[r_rd_ptr];
    assign do_push    = i_wr.push && !o_rd.full;
    assign do_pop     = i_pop && !o_rd.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wr.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

FILE: src/tot_back.sv
module tot_back
    import tot_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_q_rd             i_rd,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output t_status           o_status,
    output logic signed [OFFSET_W-1:0] o_nano_offset
);

    typedef enum logic [2:0] {S_IDLE, S_MUL1, S_MUL2, S_SUM, S_FIN} t_state;

    t_state                      r_state;
    t_job                        r_job;
    logic [SECS_W-1:0]           r_secs;
    logic [MS_W-1:0]             r_ms;
    logic [NS_W-1:0]             r_ns_s;
    logic [NS_W-1:0]             r_ns_ms;
    logic [NS_W-1:0]             r_sum;
    logic                        r_out_valid;
    t_status                     r_out_status;
    logic signed [OFFSET_W-1:0]  r_out_offset;
    logic                        out_free;

    assign out_free      = !r_out_valid || i_ready;
    assign o_pop         = (r_state == S_IDLE) && !i_rd.empty;
    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_nano_offset = r_out_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // The final step reloads the output register itself when it is taken.
            if (r_out_valid && i_ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_rd.empty) begin
                        r_job   <= i_rd.job;
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_secs  <= SECS_W'(r_job.hours) * SECS_W'(SEC_PER_HOUR)
                             + SECS_W'(r_job.minutes) * SECS_W'(SEC_PER_MIN)
                             + SECS_W'(r_job.seconds);
                    r_ms    <= MS_W'(MS_W'(r_job.frac) * MS_W'(frac_scale(r_job.frac_digits)));
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_ns_s  <= NS_W'(r_secs) * NS_W'(NS_PER_S);
                    r_ns_ms <= NS_W'(r_ms) * NS_W'(NS_PER_MS);
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_sum   <= r_ns_s + r_ns_ms;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                        if (r_job.kind != ST_VALID) begin
                            r_out_status <= r_job.kind;
                            r_out_offset <= '0;
                        end else if (r_job.neg && (r_sum == '0)) begin
                            r_out_status <= ST_NEGZERO;
                            r_out_offset <= '0;
                        end else if (r_job.neg) begin
                            r_out_status <= ST_VALID;
                            r_out_offset <= -$signed(OFFSET_W'(r_sum));
                        end else begin
                            r_out_status <= ST_VALID;
                            r_out_offset <= $signed(OFFSET_W'(r_sum));
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_zero_unless_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != ST_VALID)) |-> (r_out_offset == '0))
        else $error("nonzero offset with a non-valid status");
    a_fin_after_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIN) && ($past(r_state) != S_FIN)) |-> ($past(r_state) == S_SUM))
        else $error("final step entered without the sum step");
    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> ($past(r_state) == S_FIN))
        else $error("result appeared outside the final step");
    a_sign_of_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ((r_out_status != ST_VALID) || (r_out_offset == '0)
            || (r_out_offset[OFFSET_W-1] == r_job.neg)))
        else $error("result sign does not follow the parsed sign");
`endif

endmodule

FILE: src/time_offset_text_parser.sv
// Parses a time offset string, one character per word, into a status and a signed
// nanosecond offset. The string is either "auto" or [-]HH:MM:SS[.mmm], with the final
// character flagged by last_char; one result word follows each flagged character. The
// parser takes a character in every cycle while its job queue (QUEUE_DEPTH strings) has
// room. The arithmetic side takes one string at a time through its steps (load, the seconds
// sum with the fraction scaling, the multiply by the nanosecond constants, a 62-bit add and
// the final sign step, which waits until the output register is free) and holds the result
// in that output register until it is taken.
module time_offset_text_parser
    import tot_pkg::*;
#(
    parameter int MAX_HOUR_DIGITS = MAX_HOUR_DIGITS_DEF,
    parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF,
    parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tot_in_if.sink    i_in,
    tot_out_if.source o_out
);

    t_q_wr   wr;
    t_q_rd   rd;
    logic    pop;
    t_status status;

    tot_front #(
        .MAX_HOUR_DIGITS(MAX_HOUR_DIGITS),
        .FRACTION_DIGITS(FRACTION_DIGITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .o_ready     (i_in.ready),
        .i_text_char (i_in.text_char),
        .i_last_char (i_in.last_char),
        .i_full      (rd.full),
        .o_wr        (wr)
    );

    tot_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_pop   (pop),
        .o_rd    (rd)
    );

    tot_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rd          (rd),
        .o_pop         (pop),
        .o_valid       (o_out.valid),
        .i_ready       (o_out.ready),
        .o_status      (status),
        .o_nano_offset (o_out.nano_offset)
    );

    assign o_out.status = status;

endmodule
